// ----- design/mrpt_pkg.sv -----
// package for the miller-rabin prime test unit: widths, bases, state codes
package mrpt_pkg;

  localparam int NumberWidth = 63;
  localparam int BaseCount   = 7;
  localparam int BaseIdxW    = 3;
  localparam int BaseWidth   = 31;
  localparam int BitIdxW     = 6;
  localparam int TdataWidth  = 64;

  typedef logic [NumberWidth-1:0] num_t;

  // fixed base set, deterministic below 2^64
  function automatic logic [BaseWidth-1:0] base_at(input logic [BaseIdxW-1:0] idx);
    logic [BaseWidth-1:0] b;
    begin
      case (idx)
        3'd0:    b = 31'd2;
        3'd1:    b = 31'd325;
        3'd2:    b = 31'd9375;
        3'd3:    b = 31'd28178;
        3'd4:    b = 31'd450775;
        3'd5:    b = 31'd9780504;
        3'd6:    b = 31'd1795265022;
        default: b = 31'd0;
      endcase
      base_at = b;
    end
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCREEN,    // serial mod-3 and mod-5 residues for trial division by 3, 5
    ST_ODD,       // screen small values and 2, 3, 5; strip trailing zeros of n-1
    ST_BASE,      // start reduction of next base mod n
    ST_RED,       // bit-serial reduction of base
    ST_EXP_MUL,   // v = v*b mod n when exponent bit set
    ST_EXP_WAIT1,
    ST_EXP_SQR,   // loop to next exponent bit once b = b*b mod n is stored
    ST_EXP_WAIT2,
    ST_CHECK,     // skip base whose residue mod n is zero; clear square count
    ST_SQ_TEST,   // compare v with n-1 / 1
    ST_SQ_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } mm_ctl_t;

endpackage

// ----- design/mrpt_mulmod.sv -----
// bit-serial modular multiplier: one bit of the multiplier per cycle
module mrpt_mulmod (
  input  logic               clk,
  input  logic               rst,
  input  mrpt_pkg::mm_ctl_t  ctl_in,
  input  mrpt_pkg::num_t     a,
  input  mrpt_pkg::num_t     b,
  input  mrpt_pkg::num_t     m,
  output logic               busy,
  output mrpt_pkg::num_t     p
);
  mrpt_pkg::num_t       x;
  mrpt_pkg::num_t       y;
  mrpt_pkg::num_t       acc;
  logic [63:0]          s_acc;
  logic [63:0]          s_x;
  mrpt_pkg::num_t       acc_next;
  mrpt_pkg::num_t       x_next;

  // add_mod for accumulator and doubled operand
  always_comb begin
    s_acc    = {1'b0, acc} + {1'b0, x};
    acc_next = (s_acc >= {1'b0, m}) ? 63'(s_acc - {1'b0, m}) : 63'(s_acc);
    if (!y[0]) acc_next = acc;
    s_x      = {1'b0, x} + {1'b0, x};
    x_next   = (s_x >= {1'b0, m}) ? 63'(s_x - {1'b0, m}) : 63'(s_x);
  end

  // operand shifting
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl_in.start) begin
      busy <= 1'b1;
    end else if (busy && y == '0) begin
      busy <= 1'b0;
    end
    if (ctl_in.start) begin
      x   <= a;
      y   <= b;
      acc <= '0;
    end else if (busy && y != '0) begin
      x   <= x_next;
      y   <= y >> 1;
      acc <= acc_next;
    end
  end

  assign p = acc;

  logic unused_busy;
  assign unused_busy = ctl_in.busy;
endmodule

// ----- design/miller_rabin_prime_test_unit.sv -----
// top level of the miller-rabin prime test unit
//   channel | dir | fields
//   s_axis  | in  | tdata[62:0] number
//   m_axis  | out | tdata[0] is_prime
// a full test takes up to about 7 bases * ~126 multiplies, its time set by the
// bit-serial modular multiplier (one multiplier bit per cycle); screened values
// finish after the serial trial division over the 63 bits of the number. one
// number at a time; tready is low while testing.
// rst is synchronous and clears control. a waiting result holds until taken.
module miller_rabin_prime_test_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [62:0] number
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] is_prime
);
  mrpt_pkg::state_t state, state_next;
  mrpt_pkg::num_t   n, nm1, u, e, v, bb, r_acc;
  logic [mrpt_pkg::BaseIdxW-1:0] bidx;
  logic [mrpt_pkg::BitIdxW-1:0]  s_cnt, r_cnt, bit_cnt;
  logic [1:0] m3;
  logic [2:0] m5;
  logic [2:0] m3_sh;
  logic [3:0] m5_sh;
  logic       result;
  logic       out_valid;
  logic       pass_now;
  logic       sq_more;
  logic       mm_go;

  mrpt_pkg::mm_ctl_t mm_ctl;
  mrpt_pkg::num_t    mm_a, mm_b, mm_p;
  logic              mm_busy;

  mrpt_mulmod u_mm (
    .clk(clk), .rst(rst), .ctl_in(mm_ctl), .a(mm_a), .b(mm_b), .m(n),
    .busy(mm_busy), .p(mm_p)
  );

  assign s_axis_tready = (state == mrpt_pkg::ST_IDLE) && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, result};

  logic [63:0] r_sh;
  assign r_sh = {r_acc, bb[bit_cnt]} ;

  // shifted residues for the serial mod-3 and mod-5 screen
  assign m3_sh = {m3, n[bit_cnt]};
  assign m5_sh = {m5, n[bit_cnt]};

  // strong test outcome for the current square
  assign pass_now = (r_cnt == '0 && v == 63'd1) || (r_cnt < s_cnt && v == nm1);
  assign sq_more  = (v != 63'd1) && (r_cnt < s_cnt);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mrpt_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mrpt_pkg::ST_DONE) out_valid <= 1'b1;
      else if (out_valid && m_axis_tready) out_valid <= 1'b0;
    end
  end

  // datapath registers and serial residues
  always_ff @(posedge clk) begin
    mm_ctl.start <= mm_go;
    mm_ctl.busy  <= mm_busy;
    case (state)
      mrpt_pkg::ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          n       <= s_axis_tdata[62:0];
          bit_cnt <= 6'd62;
          m3      <= 2'd0;
          m5      <= 3'd0;
        end
      end
      mrpt_pkg::ST_SCREEN: begin
        // one bit per cycle into mod-3 and mod-5 residues
        m3 <= (m3_sh >= 3'd3) ? 2'(m3_sh - 3'd3) : m3_sh[1:0];
        m5 <= (m5_sh >= 4'd5) ? 3'(m5_sh - 4'd5) : m5_sh[2:0];
        bit_cnt <= bit_cnt - 6'd1;
        nm1  <= n - 63'd1;
        u    <= n - 63'd1;
        s_cnt <= '0;
      end
      mrpt_pkg::ST_ODD: begin
        if (!u[0]) begin
          u     <= u >> 1;
          s_cnt <= s_cnt + 6'd1;
        end
      end
      mrpt_pkg::ST_BASE: begin
        bb      <= 63'(mrpt_pkg::base_at(bidx));
        r_acc   <= '0;
        bit_cnt <= 6'd30;
      end
      mrpt_pkg::ST_RED: begin
        // restoring reduction, one bit of the base per cycle
        r_acc   <= (r_sh >= {1'b0, n}) ? 63'(r_sh - {1'b0, n})
                                       : r_sh[62:0];
        bit_cnt <= bit_cnt - 6'd1;
        if (bit_cnt == 6'd0) begin
          e <= u;
          v <= 63'd1;
        end
      end
      mrpt_pkg::ST_EXP_MUL: begin
        if (bit_cnt == 6'd63) bb <= r_acc;
        bit_cnt <= 6'd0;
        if (e[0]) begin
          mm_a <= v; mm_b <= (bit_cnt == 6'd63) ? r_acc : bb;
        end
      end
      mrpt_pkg::ST_EXP_WAIT1: begin
        if (!mm_ctl.start && !mm_busy && e[0]) v <= mm_p;
        if (!mm_ctl.start && !mm_busy) begin
          mm_a <= bb; mm_b <= bb;
        end
      end
      mrpt_pkg::ST_EXP_WAIT2: begin
        if (!mm_ctl.start && !mm_busy) begin
          bb <= mm_p;
          e  <= e >> 1;
        end
      end
      mrpt_pkg::ST_CHECK: begin
        r_cnt <= '0;
      end
      mrpt_pkg::ST_SQ_TEST: begin
        mm_a <= v; mm_b <= v;
      end
      mrpt_pkg::ST_SQ_WAIT: begin
        if (!mm_ctl.start && !mm_busy) begin
          v     <= mm_p;
          r_cnt <= r_cnt + 6'd1;
        end
      end
      default: ;
    endcase
  end

  // next state, multiplier start and verdict
  always_comb begin
    state_next = state;
    mm_go      = 1'b0;
    case (state)
      mrpt_pkg::ST_IDLE:
        if (s_axis_tvalid && s_axis_tready) state_next = mrpt_pkg::ST_SCREEN;
      mrpt_pkg::ST_SCREEN:
        if (bit_cnt == 6'd0) state_next = mrpt_pkg::ST_ODD;
      mrpt_pkg::ST_ODD: begin
        if (n == 63'd2 || n == 63'd3 || n == 63'd5 || n < 63'd2 || !n[0]
            || m3 == 2'd0 || m5 == 3'd0)
          state_next = mrpt_pkg::ST_DONE;
        else if (u[0]) state_next = mrpt_pkg::ST_BASE;
      end
      mrpt_pkg::ST_BASE:   state_next = mrpt_pkg::ST_RED;
      mrpt_pkg::ST_RED:
        if (bit_cnt == 6'd0) state_next = mrpt_pkg::ST_CHECK;
      mrpt_pkg::ST_EXP_MUL: begin
        mm_go      = e[0];
        state_next = mrpt_pkg::ST_EXP_WAIT1;
      end
      mrpt_pkg::ST_EXP_WAIT1:
        if (!mm_ctl.start && !mm_busy) begin
          mm_go      = 1'b1;
          state_next = mrpt_pkg::ST_EXP_WAIT2;
        end
      mrpt_pkg::ST_EXP_WAIT2:
        if (!mm_ctl.start && !mm_busy) state_next = mrpt_pkg::ST_EXP_SQR;
      mrpt_pkg::ST_EXP_SQR:
        state_next = (e == '0) ? mrpt_pkg::ST_SQ_TEST : mrpt_pkg::ST_EXP_MUL;
      mrpt_pkg::ST_CHECK: begin
        // base residue zero means skip
        if (r_acc == '0)
          state_next = (bidx == 3'(mrpt_pkg::BaseCount - 1))
                       ? mrpt_pkg::ST_DONE : mrpt_pkg::ST_BASE;
        else state_next = mrpt_pkg::ST_EXP_MUL;
      end
      mrpt_pkg::ST_SQ_TEST: begin
        if (pass_now)
          state_next = (bidx == 3'(mrpt_pkg::BaseCount - 1))
                       ? mrpt_pkg::ST_DONE : mrpt_pkg::ST_BASE;
        else if (sq_more) begin
          mm_go      = 1'b1;
          state_next = mrpt_pkg::ST_SQ_WAIT;
        end else state_next = mrpt_pkg::ST_DONE;
      end
      mrpt_pkg::ST_SQ_WAIT:
        if (!mm_ctl.start && !mm_busy) state_next = mrpt_pkg::ST_SQ_TEST;
      mrpt_pkg::ST_DONE:   state_next = mrpt_pkg::ST_IDLE;
      default:             state_next = mrpt_pkg::ST_IDLE;
    endcase
  end

  // verdict register, base index advance
  always_ff @(posedge clk) begin
    if (state == mrpt_pkg::ST_SCREEN) begin
      bidx <= '0;
    end
    if (state == mrpt_pkg::ST_ODD) begin
      result <= (n == 63'd2 || n == 63'd3 || n == 63'd5);
    end
    if (state == mrpt_pkg::ST_CHECK && r_acc == '0) begin
      bidx <= bidx + 3'd1;
      if (bidx == 3'(mrpt_pkg::BaseCount - 1)) result <= 1'b1;
    end
    if (state == mrpt_pkg::ST_SQ_TEST) begin
      if (pass_now) begin
        if (bidx == 3'(mrpt_pkg::BaseCount - 1)) result <= 1'b1;
        bidx <= bidx + 3'd1;
      end else result <= 1'b0;
    end
  end

  logic unused_bits;
  assign unused_bits = s_axis_tdata[63];
endmodule
